@@ rtl/u2u8enc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8enc_pkg
// Shared types and constants for the UCS-2 to UTF-8 stream encoder.
// ----------------------------------------------------------------------------
package u2u8enc_pkg;

	localparam int UNIT_W   = 16;
	localparam int BYTE_W   = 8;
	localparam int COUNT_W  = 12;
	localparam int CAP_W    = 13;
	localparam int CFG_IDX_W = 4;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWAP     = 4'd1;

	localparam logic [CAP_W-1:0] CAPACITY_RESET = 13'd512;
	localparam logic [CAP_W-1:0] CAPACITY_LIMIT = 13'd4096;

	// UTF-8 range limits and lead/continuation marks
	localparam logic [UNIT_W-1:0] LIMIT_ONE_BYTE = 16'h0080;
	localparam logic [UNIT_W-1:0] LIMIT_TWO_BYTE = 16'h0800;
	localparam logic [BYTE_W-1:0] LEAD_TWO       = 8'hC0;
	localparam logic [BYTE_W-1:0] LEAD_THREE     = 8'hE0;
	localparam logic [BYTE_W-1:0] CONT_MARK      = 8'h80;

	// one queued job for the back end: an encoded character or an end result
	typedef struct packed {
		logic                is_end;
		logic                trunc;
		logic [1:0]          nbytes;
		logic [BYTE_W-1:0]   byte0;
		logic [BYTE_W-1:0]   byte1;
		logic [BYTE_W-1:0]   byte2;
		logic [COUNT_W-1:0]  base_count;
	} entry_t;

	// queue status seen by the input handshake and the back end
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage : u2u8enc_pkg
`default_nettype wire

@@ rtl/u2u8enc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8enc_front
// Accepts code units, swaps and classifies them, applies the capacity check
// and keeps the per-string byte count and truncation state.
// ----------------------------------------------------------------------------
module u2u8enc_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire logic [u2u8enc_pkg::UNIT_W-1:0]      code_unit,
	input  wire logic [u2u8enc_pkg::CAP_W-1:0]       capacity,
	input  wire logic                                swap_bytes,
	output      logic                                push,
	output      u2u8enc_pkg::entry_t                 push_entry
);
	import u2u8enc_pkg::*;

	logic [COUNT_W-1:0] written_q;
	logic               stopped_q;

	logic [UNIT_W-1:0]  unit_sw;
	logic               is_zero;
	logic [1:0]         nbytes;
	logic [BYTE_W-1:0]  b0, b1, b2;
	logic [CAP_W-1:0]   cap_eff;
	logic [CAP_W-1:0]   sum;
	logic               fits;

	// swap and classify
	always_comb begin
		is_zero = (code_unit == '0);
		unit_sw = swap_bytes ? {code_unit[7:0], code_unit[15:8]} : code_unit;
		b1 = '0;
		b2 = '0;
		if (unit_sw < LIMIT_ONE_BYTE) begin
			nbytes = 2'd1;
			b0     = unit_sw[7:0];
		end else if (unit_sw < LIMIT_TWO_BYTE) begin
			nbytes = 2'd2;
			b0     = LEAD_TWO | {3'b000, unit_sw[10:6]};
			b1     = CONT_MARK | {2'b00, unit_sw[5:0]};
		end else begin
			nbytes = 2'd3;
			b0     = LEAD_THREE | {4'b0000, unit_sw[15:12]};
			b1     = CONT_MARK | {2'b00, unit_sw[11:6]};
			b2     = CONT_MARK | {2'b00, unit_sw[5:0]};
		end
	end

	// capacity check, one byte kept for the terminator
	always_comb begin
		cap_eff = (capacity > CAPACITY_LIMIT) ? CAPACITY_LIMIT : capacity;
		sum     = {1'b0, written_q} + {{(CAP_W-2){1'b0}}, nbytes};
		fits    = (sum < cap_eff);
	end

	// build the job for the back end
	always_comb begin
		push                  = accept && (is_zero || (!stopped_q && fits));
		push_entry.is_end     = is_zero;
		push_entry.trunc      = stopped_q;
		push_entry.nbytes     = is_zero ? 2'd1 : nbytes;
		push_entry.byte0      = is_zero ? '0 : b0;
		push_entry.byte1      = b1;
		push_entry.byte2      = b2;
		push_entry.base_count = written_q;
	end

	// advance the string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			stopped_q <= 1'b0;
		end else if (accept) begin
			if (is_zero) begin
				written_q <= '0;
				stopped_q <= 1'b0;
			end else if (!stopped_q) begin
				if (fits) begin
					written_q <= sum[COUNT_W-1:0];
				end else begin
					stopped_q <= 1'b1;
				end
			end
		end
	end

	// a string never grows past the largest capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_entry.is_end) |-> (sum < CAPACITY_LIMIT))
		else $error("front: character pushed beyond capacity limit");
	// after truncation only the end result leaves the front
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && stopped_q) |-> push_entry.is_end)
		else $error("front: character pushed after truncation");
	// an end result clears the count
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_zero) |=> (written_q == '0 && !stopped_q))
		else $error("front: string state not cleared at end");

endmodule : u2u8enc_front
`default_nettype wire

@@ rtl/u2u8enc_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8enc_queue
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module u2u8enc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire u2u8enc_pkg::entry_t         push_entry,
	input  wire logic                        pop,
	output      u2u8enc_pkg::entry_t         head,
	output      u2u8enc_pkg::queue_status_t  status
);
	import u2u8enc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	entry_t             entries_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign status.full  = (count_q == CNT_FULL);
	assign status.empty = (count_q == '0);
	assign head         = entries_q[rd_ptr_q];

	// store the pushed job
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_entry;
		end
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !status.full)
		else $error("queue: push while full");
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !status.empty)
		else $error("queue: pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue: fill count out of range");

endmodule : u2u8enc_queue
`default_nettype wire

@@ rtl/u2u8enc_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// u2u8enc_back
// Takes jobs from the queue and sends them out one byte per word through
// the output register.
// ----------------------------------------------------------------------------
module u2u8enc_back (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire u2u8enc_pkg::entry_t                 head,
	input  wire u2u8enc_pkg::queue_status_t          qstatus,
	output      logic                                pop,
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic [u2u8enc_pkg::BYTE_W-1:0]      out_byte,
	output      logic                                char_last,
	output      logic                                string_end,
	output      logic                                truncated,
	output      logic [u2u8enc_pkg::COUNT_W-1:0]     byte_count
);
	import u2u8enc_pkg::*;

	logic [1:0]          idx_q;
	logic                out_valid_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                char_last_q;
	logic                string_end_q;
	logic                truncated_q;
	logic [COUNT_W-1:0]  byte_count_q;

	logic                load;
	logic                last_byte;
	logic [BYTE_W-1:0]   sel_byte;

	// pick the next byte of the head job
	always_comb begin
		load      = !qstatus.empty && (!out_valid_q || !out_stall);
		last_byte = head.is_end || ((idx_q + 2'd1) == head.nbytes);
		pop       = load && last_byte;
		case (idx_q)
			2'd0:    sel_byte = head.byte0;
			2'd1:    sel_byte = head.byte1;
			default: sel_byte = head.byte2;
		endcase
	end

	// step through the bytes of the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= last_byte ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// hold the output word until it is taken
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= head.is_end ? '0 : sel_byte;
			char_last_q  <= last_byte;
			string_end_q <= head.is_end;
			truncated_q  <= head.is_end && head.trunc;
			byte_count_q <= head.is_end ? head.base_count
			                            : head.base_count + COUNT_W'(idx_q) + 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign char_last  = char_last_q;
	assign string_end = string_end_q;
	assign truncated  = truncated_q;
	assign byte_count = byte_count_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_end) |-> (char_last && out_byte == '0))
		else $error("back: malformed end word");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && truncated) |-> string_end)
		else $error("back: truncation flag on a data byte");
	assert property (@(posedge clk) disable iff (!arst_n)
		(!qstatus.empty && !head.is_end) |-> (idx_q < head.nbytes))
		else $error("back: byte index past end of character");

endmodule : u2u8enc_back
`default_nettype wire

@@ rtl/ucs2_to_utf8_stream_encoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ucs2_to_utf8_stream_encoder_unit
// UCS-2 to UTF-8 stream encoder: one code unit in, up to three UTF-8 bytes
// out, with an end word per string.
// ----------------------------------------------------------------------------
// A code unit is accepted in any cycle in which the job queue has room;
// units dropped for capacity and units after truncation are accepted but
// produce nothing. The back end sends one byte per cycle from a single
// output register while jobs are queued and the output is not stalled, so a
// unit gives one, two or three bytes (ASCII, two-byte, three-byte forms) and
// the zero unit that ends a string gives one end word. The output serialiser
// sets the sustained rate; the first byte of a unit passes through the job
// queue and then the output register before it is presented. Configuration
// is sampled directly and must be written while the block is idle.
// ----------------------------------------------------------------------------
module ucs2_to_utf8_stream_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write channel
	input  wire logic                                  cfg_valid,
	output      logic                                  cfg_ready,
	input  wire logic [u2u8enc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [u2u8enc_pkg::CAP_W-1:0]         cfg_data,
	// code unit input
	input  wire logic                                  in_valid,
	output      logic                                  in_stall,
	input  wire logic [u2u8enc_pkg::UNIT_W-1:0]        code_unit,
	// byte output
	output      logic                                  out_valid,
	input  wire logic                                  out_stall,
	output      logic [u2u8enc_pkg::BYTE_W-1:0]        out_byte,
	output      logic                                  char_last,
	output      logic                                  string_end,
	output      logic                                  truncated,
	output      logic [u2u8enc_pkg::COUNT_W-1:0]       byte_count
);
	import u2u8enc_pkg::*;

	logic [CAP_W-1:0]  capacity_q;
	logic              swap_q;
	logic              in_accept;
	logic              push;
	logic              pop;
	entry_t            push_entry;
	entry_t            head;
	queue_status_t     qstatus;

	assign cfg_ready = 1'b1;
	assign in_stall  = qstatus.full;
	assign in_accept = in_valid && !in_stall;

	// decode configuration writes; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
			swap_q     <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CAPACITY: capacity_q <= cfg_data;
				REG_SWAP:     swap_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	u2u8enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.code_unit  (code_unit),
		.capacity   (capacity_q),
		.swap_bytes (swap_q),
		.push       (push),
		.push_entry (push_entry)
	);

	u2u8enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (qstatus)
	);

	u2u8enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.qstatus    (qstatus),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.char_last  (char_last),
		.string_end (string_end),
		.truncated  (truncated),
		.byte_count (byte_count)
	);

endmodule : ucs2_to_utf8_stream_encoder_unit
`default_nettype wire

@@ dv/ucs2_to_utf8_stream_encoder_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs2_to_utf8_stream_encoder_unit_test
// Self-checking bench for the UCS-2 to UTF-8 stream encoder. A directed table
// covers the encoding boundaries, byte swapping, capacity truncation and
// register writes. Random strings then run under several capacity and swap
// settings. Output words are checked against typed rows or an in-bench encoder.
// ----------------------------------------------------------------------------
module ucs2_to_utf8_stream_encoder_unit_test;
	import u2u8enc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_UNITS = 65;
	localparam int SETTLE_CYCLES = 8;

	// one output word as the encoder should present it
	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               last;
		logic               eos;
		logic               trunc;
		logic [COUNT_W-1:0] count;
	} utf8_word_t;

	typedef enum logic {ROW_UNIT, ROW_CFG} row_kind_t;

	// one step of the directed table: a code unit or a register write
	typedef struct packed {
		row_kind_t          kind;
		logic [CFG_IDX_W-1:0] idx;
		logic [UNIT_W-1:0]  value;
		logic               typed;
		logic [1:0]         n;
		utf8_word_t         w0;
		utf8_word_t         w1;
		utf8_word_t         w2;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CAP_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [UNIT_W-1:0]    code_unit;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [BYTE_W-1:0]    out_byte;
	logic                 char_last;
	logic                 string_end;
	logic                 truncated;
	logic [COUNT_W-1:0]   byte_count;

	// shadow of the encoder's registers and string state
	logic [CAP_W-1:0]   sh_capacity = CAPACITY_RESET;
	logic               sh_swap = 1'b1;
	logic [COUNT_W-1:0] sh_written = '0;
	logic               sh_stopped = 1'b0;

	utf8_word_t expected_words[$];
	dir_row_t   cur_row;
	dir_row_t   dir_table[$];

	int src_idle = 0;
	int sink_stall = 0;
	int errors = 0;
	int idle_cycles = 0;
	int units_in = 0;
	int words_out = 0;
	int strings_done = 0;
	int strings_cut = 0;
	int cfg_writes = 0;

	ucs2_to_utf8_stream_encoder_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.code_unit  (code_unit),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.char_last  (char_last),
		.string_end (string_end),
		.truncated  (truncated),
		.byte_count (byte_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// stall the output side at random
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < sink_stall);
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns mismatch: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("%s got %0h want %0h on word %0d", name, got, want,
				words_out));
	endtask

	// encode one code unit against the shadow state; returns the word count
	function automatic int encode_unit(input logic [UNIT_W-1:0] loaded,
			output utf8_word_t w [3]);
		logic [UNIT_W-1:0] cp;
		logic [BYTE_W-1:0] b [3];
		int n;
		int cap;
		cap = (sh_capacity > CAPACITY_LIMIT) ? CAPACITY_LIMIT : sh_capacity;
		// the terminator is tested before any swap
		if (loaded == '0) begin
			w[0] = '{8'h00, 1'b1, 1'b1, sh_stopped, sh_written};
			sh_written = '0;
			sh_stopped = 1'b0;
			return 1;
		end
		cp = sh_swap ? {loaded[7:0], loaded[15:8]} : loaded;
		if (cp < LIMIT_ONE_BYTE) begin
			b[0] = cp[7:0];
			n = 1;
		end else if (cp < LIMIT_TWO_BYTE) begin
			b[0] = LEAD_TWO | {3'b000, cp[10:6]};
			b[1] = CONT_MARK | {2'b00, cp[5:0]};
			n = 2;
		end else begin
			b[0] = LEAD_THREE | {4'b0000, cp[15:12]};
			b[1] = CONT_MARK | {2'b00, cp[11:6]};
			b[2] = CONT_MARK | {2'b00, cp[5:0]};
			n = 3;
		end
		// drop the rest of the string once capacity is hit
		if (sh_stopped)
			return 0;
		if (int'(sh_written) + n >= cap) begin
			sh_stopped = 1'b1;
			return 0;
		end
		for (int i = 0; i < n; i++) begin
			sh_written++;
			w[i] = '{b[i], (i == n - 1), 1'b0, 1'b0, sh_written};
		end
		return n;
	endfunction

	// check output words, track register writes and predict accepted units
	always @(posedge clk) begin
		utf8_word_t w [3];
		utf8_word_t want;
		int n;
		logic busy;
		if (arst_n) begin
			busy = 1'b0;
			if (out_valid && !out_stall) begin
				busy = 1'b1;
				if (expected_words.size() == 0) begin
					report_mismatch($sformatf("word %0h arrived with nothing expected",
						out_byte));
				end else begin
					want = expected_words.pop_front();
					check_field("out_byte", int'(out_byte), int'(want.data));
					check_field("char_last", int'(char_last), int'(want.last));
					check_field("string_end", int'(string_end), int'(want.eos));
					check_field("truncated", int'(truncated), int'(want.trunc));
					check_field("byte_count", int'(byte_count), int'(want.count));
				end
				words_out++;
				if (string_end) begin
					strings_done++;
					if (truncated)
						strings_cut++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				busy = 1'b1;
				cfg_writes++;
				case (cfg_index)
					REG_CAPACITY: sh_capacity = cfg_data;
					REG_SWAP:     sh_swap = cfg_data[0];
					default:      ;
				endcase
			end
			if (in_valid && !in_stall) begin
				busy = 1'b1;
				units_in++;
				n = encode_unit(code_unit, w);
				// typed rows carry their own expectation; the shadow still advances
				if (cur_row.typed) begin
					if (cur_row.n > 0)
						expected_words.push_back(cur_row.w0);
					if (cur_row.n > 1)
						expected_words.push_back(cur_row.w1);
					if (cur_row.n > 2)
						expected_words.push_back(cur_row.w2);
				end else begin
					for (int i = 0; i < n; i++)
						expected_words.push_back(w[i]);
				end
			end
			idle_cycles = busy ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("ucs2_to_utf8_stream_encoder_unit regression: fail");
				$finish;
			end
		end
	end

	function automatic utf8_word_t mk_word(input logic [BYTE_W-1:0] d, input int l,
			input int e, input int t, input logic [COUNT_W-1:0] c);
		return '{d, 1'(l), 1'(e), 1'(t), c};
	endfunction

	function automatic dir_row_t unit_row(input logic [UNIT_W-1:0] u);
		return '{ROW_UNIT, '0, u, 1'b0, 2'd0, '0, '0, '0};
	endfunction

	function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [UNIT_W-1:0] d);
		return '{ROW_CFG, idx, d, 1'b0, 2'd0, '0, '0, '0};
	endfunction

	function automatic dir_row_t typed_row(input logic [UNIT_W-1:0] u, input logic [1:0] n,
			input utf8_word_t w0, input utf8_word_t w1, input utf8_word_t w2);
		return '{ROW_UNIT, '0, u, 1'b1, n, w0, w1, w2};
	endfunction

	// present one code unit and hold it until accepted
	task automatic send_unit(input dir_row_t r);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		cur_row = r;
		in_valid <= 1'b1;
		code_unit <= r.value;
		do @(posedge clk); while (in_stall);
	endtask

	// hold off the input until every expected word has come out
	task automatic drain_words();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CAP_W-1:0] d);
		drain_words();
		// let dropped units finish before touching the registers
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [CAP_W-1:0] caps [6];
		logic             swaps [6];
		logic [UNIT_W-1:0] cp;
		logic [UNIT_W-1:0] u;
		int sent;
		int len;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		code_unit = '0;
		cur_row = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// reset state: swapped input, capacity 512
		dir_table.push_back(typed_row(16'h4100, 2'd1, mk_word(8'h41, 1, 0, 0, 12'd1), '0, '0));
		dir_table.push_back(typed_row(16'h0000, 2'd1, mk_word(8'h00, 1, 1, 0, 12'd1), '0, '0));
		dir_table.push_back(unit_row(16'hAC20));
		dir_table.push_back(unit_row(16'h0000));
		// range boundaries of each encoding length, unswapped
		dir_table.push_back(cfg_row(REG_SWAP, 16'd0));
		dir_table.push_back(typed_row(16'h0001, 2'd1, mk_word(8'h01, 1, 0, 0, 12'd1), '0, '0));
		dir_table.push_back(typed_row(16'h007F, 2'd1, mk_word(8'h7F, 1, 0, 0, 12'd2), '0, '0));
		dir_table.push_back(typed_row(16'h0080, 2'd2, mk_word(8'hC2, 0, 0, 0, 12'd3),
			mk_word(8'h80, 1, 0, 0, 12'd4), '0));
		dir_table.push_back(typed_row(16'h07FF, 2'd2, mk_word(8'hDF, 0, 0, 0, 12'd5),
			mk_word(8'hBF, 1, 0, 0, 12'd6), '0));
		dir_table.push_back(typed_row(16'h0800, 2'd3, mk_word(8'hE0, 0, 0, 0, 12'd7),
			mk_word(8'hA0, 0, 0, 0, 12'd8), mk_word(8'h80, 1, 0, 0, 12'd9)));
		dir_table.push_back(typed_row(16'hFFFF, 2'd3, mk_word(8'hEF, 0, 0, 0, 12'd10),
			mk_word(8'hBF, 0, 0, 0, 12'd11), mk_word(8'hBF, 1, 0, 0, 12'd12)));
		dir_table.push_back(typed_row(16'h0000, 2'd1, mk_word(8'h00, 1, 1, 0, 12'd12), '0, '0));
		// capacity four: three bytes fit, then the string is cut
		dir_table.push_back(cfg_row(REG_CAPACITY, 16'd4));
		dir_table.push_back(typed_row(16'h0041, 2'd1, mk_word(8'h41, 1, 0, 0, 12'd1), '0, '0));
		dir_table.push_back(typed_row(16'h0042, 2'd1, mk_word(8'h42, 1, 0, 0, 12'd2), '0, '0));
		dir_table.push_back(typed_row(16'h0043, 2'd1, mk_word(8'h43, 1, 0, 0, 12'd3), '0, '0));
		dir_table.push_back(typed_row(16'h0044, 2'd0, '0, '0, '0));
		dir_table.push_back(typed_row(16'h0045, 2'd0, '0, '0, '0));
		dir_table.push_back(typed_row(16'h0000, 2'd1, mk_word(8'h00, 1, 1, 1, 12'd3), '0, '0));
		// capacity zero drops everything
		dir_table.push_back(cfg_row(REG_CAPACITY, 16'd0));
		dir_table.push_back(typed_row(16'h0041, 2'd0, '0, '0, '0));
		dir_table.push_back(typed_row(16'h0000, 2'd1, mk_word(8'h00, 1, 1, 1, 12'd0), '0, '0));
		// a write to an unknown index leaves capacity at zero
		dir_table.push_back(cfg_row(REG_UNUSED, 16'd5));
		dir_table.push_back(unit_row(16'h0042));
		dir_table.push_back(unit_row(16'h0000));
		// a three-byte character that exactly meets capacity is dropped
		dir_table.push_back(cfg_row(REG_CAPACITY, 16'd3));
		dir_table.push_back(unit_row(16'h20AC));
		dir_table.push_back(unit_row(16'h0061));
		dir_table.push_back(unit_row(16'h0000));
		// oversized capacity with swapping back on
		dir_table.push_back(cfg_row(REG_CAPACITY, 16'h1FFF));
		dir_table.push_back(cfg_row(REG_SWAP, 16'd1));
		dir_table.push_back(unit_row(16'h00FF));
		dir_table.push_back(unit_row(16'h0100));
		dir_table.push_back(unit_row(16'hFFFF));
		dir_table.push_back(unit_row(16'h0000));

		src_idle = 13;
		sink_stall = 77;
		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_CFG)
				write_reg(dir_table[i].idx, dir_table[i].value[CAP_W-1:0]);
			else
				send_unit(dir_table[i]);
		end

		// random strings under a spread of register settings
		caps = '{CAP_W'($urandom_range(2, 24)), CAPACITY_LIMIT, 13'd1,
			CAP_W'($urandom_range(5, 40)), 13'h1FFF, CAP_W'($urandom_range(2, 60))};
		swaps = '{1'b0, 1'b1, 1'($urandom_range(1)), 1'b1, 1'b0, 1'($urandom_range(1))};
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_CAPACITY, caps[p]);
			write_reg(REG_SWAP, {12'd0, swaps[p]});
			src_idle = (p < 2) ? 13 : (p < 4) ? 77 : 0;
			sink_stall = (p < 2) ? 77 : (p < 4) ? 13 : 0;
			sent = 0;
			while (sent < PHASE_UNITS) begin
				len = ($urandom_range(11) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 10);
				for (int k = 0; k < len; k++) begin
					// pick a code point by encoding length or a raw random unit, then load it as stored
					case ($urandom_range(9))
						0, 1, 2, 3: cp = UNIT_W'($urandom_range(16'h0001, 16'h007F));
						4, 5:       cp = UNIT_W'($urandom_range(16'h0080, 16'h07FF));
						6, 7:       cp = UNIT_W'($urandom_range(16'h0800, 16'hFFFF));
						8: begin
							case ($urandom_range(5))
								0: cp = 16'h0001;
								1: cp = 16'h007F;
								2: cp = 16'h0080;
								3: cp = 16'h07FF;
								4: cp = 16'h0800;
								default: cp = 16'hFFFF;
							endcase
						end
						default:    cp = '0;
					endcase
					if (cp == '0)
						u = UNIT_W'($urandom);
					else
						u = swaps[p] ? {cp[7:0], cp[15:8]} : cp;
					send_unit(unit_row(u));
					sent++;
				end
				// now and then leave a string unterminated so it runs into the next
				if ($urandom_range(19) != 0) begin
					send_unit(unit_row('0));
					sent++;
				end
				if ($urandom_range(9) == 0)
					drain_words();
			end
		end

		drain_words();
		repeat (20) @(negedge clk);
		$display("Run covered %0d code units and %0d output words across %0d strings",
			units_in, words_out, strings_done);
		$display("(%0d cut short for capacity) with %0d register writes.", strings_cut,
			cfg_writes);
		if (errors == 0)
			$display("ucs2_to_utf8_stream_encoder_unit regression: pass");
		else
			$display("ucs2_to_utf8_stream_encoder_unit regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/u2u8enc_pkg.sv
rtl/u2u8enc_front.sv
rtl/u2u8enc_queue.sv
rtl/u2u8enc_back.sv
rtl/ucs2_to_utf8_stream_encoder_unit.sv
dv/ucs2_to_utf8_stream_encoder_unit_test.sv
